[hw/rtl/stack_bytecode_executor_defines.svh]
// Assertion macros used by the stack bytecode executor checker
`ifndef STACK_BYTECODE_EXECUTOR_DEFINES_SVH
`define STACK_BYTECODE_EXECUTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define SBE_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define SBE_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/sbe_pkg.sv]
// Shared types, constants and codes of the stack bytecode executor
`default_nettype none

package sbe_pkg;

  localparam int unsigned DATA_W          = 32;
  localparam int unsigned PC_W            = 16;
  localparam int unsigned OP_W            = 5;
  localparam int unsigned VIDX_W          = 8;
  localparam int unsigned STATUS_W        = 4;
  localparam int unsigned STACK_DEPTH_DEF = 64;
  localparam int unsigned VAR_COUNT_DEF   = 256;

  typedef enum logic [OP_W-1:0] {
    OP_CONST = 5'd0,  OP_LOAD  = 5'd1,  OP_STORE = 5'd2,  OP_ADD   = 5'd3,
    OP_SUB   = 5'd4,  OP_MUL   = 5'd5,  OP_DIV   = 5'd6,  OP_MOD   = 5'd7,
    OP_LT    = 5'd8,  OP_GT    = 5'd9,  OP_LE    = 5'd10, OP_GE    = 5'd11,
    OP_EQ    = 5'd12, OP_NE    = 5'd13, OP_AND   = 5'd14, OP_OR    = 5'd15,
    OP_NOT   = 5'd16, OP_POP   = 5'd17, OP_DUP   = 5'd18, OP_JUMP  = 5'd19,
    OP_JF    = 5'd20, OP_JT    = 5'd21, OP_PRINT = 5'd22, OP_HALT  = 5'd23
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 4'd0,
    ST_HALTED    = 4'd1,
    ST_LEFT      = 4'd2,
    ST_UNDERFLOW = 4'd3,
    ST_OVERFLOW  = 4'd4,
    ST_UNSET     = 4'd5,
    ST_DIV_ZERO  = 4'd6,
    ST_MOD_ZERO  = 4'd7,
    ST_BAD_OP    = 4'd8,
    ST_IGNORED   = 4'd9
  } status_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic capture;
    logic read;
    logic div_start;
    logic commit;
  } ctrl_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[hw/rtl/sbe_in_if.sv]
// Instruction word channel of the stack bytecode executor
`default_nettype none

interface sbe_in_if;
  import sbe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          req_type;
  logic signed [DATA_W-1:0] int_operand;
  logic [VIDX_W-1:0]        var_index;

  modport source (output valid, req_type, int_operand, var_index, input ready);
  modport sink   (input valid, req_type, int_operand, var_index, output ready);
endinterface

`default_nettype wire

[hw/rtl/sbe_out_if.sv]
// Result word channel of the stack bytecode executor
`default_nettype none

interface sbe_out_if;
  import sbe_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [PC_W-1:0]          next_pc;
  logic                     print_valid;
  logic signed [DATA_W-1:0] print_value;
  logic [STATUS_W-1:0]      status;

  modport source (output valid, next_pc, print_valid, print_value, status, input ready);
  modport sink   (input valid, next_pc, print_valid, print_value, status, output ready);
endinterface

`default_nettype wire

[hw/rtl/sbe_divider.sv]
// Iterative signed 32-bit divider, one quotient bit per cycle
`default_nettype none

module sbe_divider (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [sbe_pkg::DATA_W-1:0] dividend_i,
  input  wire logic [sbe_pkg::DATA_W-1:0] divisor_i,
  output logic                           done_o,
  output logic [sbe_pkg::DATA_W-1:0]      quot_o,
  output logic [sbe_pkg::DATA_W-1:0]      rem_o
);
  import sbe_pkg::*;

  localparam int unsigned CW = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] rem_q, quo_q, dvs_q;
  logic              negq_q, negr_q;
  logic [CW-1:0]     cnt_q;
  logic              busy_q, done_q;
  logic [DATA_W:0]   shifted, diff;

  // Trial subtract of the shifted partial remainder
  assign shifted = {rem_q, quo_q[DATA_W-1]};
  assign diff    = shifted - {1'b0, dvs_q};

  // Sequence the iterations
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= CW'(DATA_W);
    end else if (busy_q) begin
      cnt_q <= cnt_q - CW'(1);
      if (cnt_q == CW'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Load magnitudes, then shift in one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      quo_q  <= dividend_i[DATA_W-1] ? (~dividend_i + DATA_W'(1)) : dividend_i;
      dvs_q  <= divisor_i[DATA_W-1] ? (~divisor_i + DATA_W'(1)) : divisor_i;
      negq_q <= dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      negr_q <= dividend_i[DATA_W-1];
    end else if (busy_q) begin
      rem_q <= diff[DATA_W] ? shifted[DATA_W-1:0] : diff[DATA_W-1:0];
      quo_q <= {quo_q[DATA_W-2:0], ~diff[DATA_W]};
    end
  end

  // Restore signs: quotient truncates toward zero, remainder follows dividend
  assign quot_o = negq_q ? (~quo_q + DATA_W'(1)) : quo_q;
  assign rem_o  = negr_q ? (~rem_q + DATA_W'(1)) : rem_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

[hw/rtl/sbe_ctrl.sv]
// Controller state machine of the stack bytecode executor
`default_nettype none

module sbe_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire sbe_pkg::dp_sts_t    sts_i,
  output sbe_pkg::ctrl_cmd_t       cmd_o
);
  import sbe_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_CALC   = 5'b00100,
    S_DIVIDE = 5'b01000,
    S_WRITE  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // Advance through read, evaluate, optional divide and commit
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:   if (in_valid_i) state_d = S_READ;
      S_READ:   state_d = S_CALC;
      S_CALC:   state_d = sts_i.need_div ? S_DIVIDE : S_WRITE;
      S_DIVIDE: if (sts_i.div_done) state_d = S_WRITE;
      S_WRITE:  if (sts_i.out_free) state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else         state_q <= state_d;
  end

  // Drive datapath commands
  assign in_ready_o        = (state_q == S_IDLE);
  assign cmd_o.capture     = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.read        = (state_q == S_READ);
  assign cmd_o.div_start   = (state_q == S_CALC) && sts_i.need_div;
  assign cmd_o.commit      = (state_q == S_WRITE) && sts_i.out_free;

endmodule

`default_nettype wire

[hw/rtl/sbe_datapath.sv]
// Datapath: stack and variable memories, ALU, divider and result register
`default_nettype none

module sbe_datapath #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = sbe_pkg::VAR_COUNT_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire sbe_pkg::ctrl_cmd_t              cmd_i,
  output sbe_pkg::dp_sts_t                     sts_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [sbe_pkg::PC_W-1:0]        cfg_wdata_i,
  input  wire logic [sbe_pkg::OP_W-1:0]        req_type_i,
  input  wire logic [sbe_pkg::DATA_W-1:0]      int_operand_i,
  input  wire logic [sbe_pkg::VIDX_W-1:0]      var_index_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [sbe_pkg::PC_W-1:0]             next_pc_o,
  output logic                                 print_valid_o,
  output logic [sbe_pkg::DATA_W-1:0]           print_value_o,
  output logic [sbe_pkg::STATUS_W-1:0]         status_o
);
  import sbe_pkg::*;

  localparam int unsigned SAW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned SCW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned VAW = (VAR_COUNT > 1) ? $clog2(VAR_COUNT) : 1;
  localparam int unsigned NSLOT = 2 ** VIDX_W;

  // Architectural state
  logic [DATA_W-1:0] stack_mem [STACK_DEPTH];
  logic [DATA_W-1:0] var_mem   [VAR_COUNT];
  logic [VAR_COUNT-1:0] var_valid_q;
  logic [SCW-1:0]    count_q;
  logic [PC_W-1:0]   pc_q, plen_q;
  logic              stopped_q;

  // Captured instruction word and operands
  logic [OP_W-1:0]   type_q;
  logic [DATA_W-1:0] imm_q;
  logic [VIDX_W-1:0] vidx_q;
  logic [DATA_W-1:0] top_q, sec_q, var_rd_q;

  // Result register
  logic              out_valid_q;
  logic [PC_W-1:0]   out_pc_q;
  logic              out_pv_q;
  logic [DATA_W-1:0] out_val_q;
  logic [STATUS_W-1:0] out_st_q;

  logic [VAW-1:0]    slot_lut [NSLOT];
  logic [VAW-1:0]    slot;
  logic [SAW-1:0]    addr_top, addr_sec, push_addr;
  logic [1:0]        need;
  logic              push_src, push, dup, is_div, is_mod;
  logic [DATA_W-1:0] a, b, r, prod, div_q, div_r, pval;
  status_e           exec_st, st;
  logic [DATA_W:0]   nxt;
  logic              leave, exec, stop, div_done;
  logic [SCW-1:0]    count_d;
  logic [PC_W-1:0]   pc_d;

  // Slot table: variable index folded into the store
  for (genvar g = 0; g < NSLOT; g++) begin : g_slot
    assign slot_lut[g] = VAW'(g % VAR_COUNT);
  end
  assign slot = slot_lut[vidx_q];

  // Capture the instruction word
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      type_q <= req_type_i;
      imm_q  <= int_operand_i;
      vidx_q <= var_index_i;
    end
  end

  // Read the top two stack entries and the variable slot
  assign addr_top = SAW'(count_q - SCW'(1));
  assign addr_sec = SAW'(count_q - SCW'(2));

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      top_q    <= stack_mem[addr_top];
      sec_q    <= stack_mem[addr_sec];
      var_rd_q <= var_mem[slot];
    end
  end

  // Decode stack needs
  always_comb begin
    need = 2'd0;
    case (type_q)
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_LT, OP_GT, OP_LE, OP_GE,
      OP_EQ, OP_NE, OP_AND, OP_OR: need = 2'd2;
      OP_STORE, OP_NOT, OP_POP, OP_DUP, OP_JF, OP_JT, OP_PRINT: need = 2'd1;
      default: need = 2'd0;
    endcase
  end

  assign push_src = (type_q == OP_CONST) || (type_q == OP_LOAD) || (type_q == OP_DUP);
  assign dup      = (type_q == OP_DUP);
  assign is_div   = (type_q == OP_DIV);
  assign is_mod   = (type_q == OP_MOD);
  assign a        = (need == 2'd2) ? sec_q : top_q;
  assign b        = top_q;

  // Check the instruction for faults
  always_comb begin
    if (type_q > OP_HALT)                                  exec_st = ST_BAD_OP;
    else if (type_q == OP_HALT)                            exec_st = ST_HALTED;
    else if (count_q < SCW'(need))                         exec_st = ST_UNDERFLOW;
    else if (push_src && (count_q >= SCW'(STACK_DEPTH)))   exec_st = ST_OVERFLOW;
    else if ((type_q == OP_LOAD) && !var_valid_q[slot])    exec_st = ST_UNSET;
    else if (is_div && (b == '0))                          exec_st = ST_DIV_ZERO;
    else if (is_mod && (b == '0))                          exec_st = ST_MOD_ZERO;
    else                                                   exec_st = ST_OK;
  end

  assign sts_o.need_div = !stopped_q && (pc_q < plen_q) && (exec_st == ST_OK) &&
                          (is_div || is_mod);

  // Divide and modulo share one iterative unit
  sbe_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (a),
    .divisor_i  (b),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );
  assign sts_o.div_done = div_done;

  // Compute the pushed value
  assign prod = a * b;

  always_comb begin
    push = 1'b1;
    case (type_q)
      OP_CONST: r = imm_q;
      OP_LOAD:  r = var_rd_q;
      OP_ADD:   r = a + b;
      OP_SUB:   r = a - b;
      OP_MUL:   r = prod;
      OP_DIV:   r = div_q;
      OP_MOD:   r = div_r;
      OP_LT:    r = DATA_W'($signed(a) <  $signed(b));
      OP_GT:    r = DATA_W'($signed(a) >  $signed(b));
      OP_LE:    r = DATA_W'($signed(a) <= $signed(b));
      OP_GE:    r = DATA_W'($signed(a) >= $signed(b));
      OP_EQ:    r = DATA_W'(a == b);
      OP_NE:    r = DATA_W'(a != b);
      OP_AND:   r = DATA_W'((a != '0) && (b != '0));
      OP_OR:    r = DATA_W'((a != '0) || (b != '0));
      OP_NOT:   r = DATA_W'(a == '0);
      OP_DUP:   r = a;
      default: begin
        r    = '0;
        push = 1'b0;
      end
    endcase
  end

  // Pick the next pc, sign extended to catch negative targets
  always_comb begin
    nxt = (DATA_W+1)'(pc_q) + (DATA_W+1)'(1);
    case (type_q)
      OP_JUMP: nxt = {imm_q[DATA_W-1], imm_q};
      OP_JF:   if (a == '0) nxt = {imm_q[DATA_W-1], imm_q};
      OP_JT:   if (a != '0) nxt = {imm_q[DATA_W-1], imm_q};
      default: nxt = (DATA_W+1)'(pc_q) + (DATA_W+1)'(1);
    endcase
  end

  assign leave = nxt[DATA_W] || (nxt[DATA_W-1:0] >= DATA_W'(plen_q));

  // Resolve the outcome of the word
  always_comb begin
    exec = 1'b0;
    stop = 1'b0;
    pc_d = pc_q;
    if (stopped_q) begin
      st = ST_IGNORED;
    end else if (pc_q >= plen_q) begin
      st   = ST_LEFT;
      stop = 1'b1;
    end else if (exec_st != ST_OK) begin
      st   = exec_st;
      stop = 1'b1;
    end else begin
      exec = 1'b1;
      stop = leave;
      st   = leave ? ST_LEFT : ST_OK;
      pc_d = nxt[PC_W-1:0];
    end
  end

  assign push_addr = SAW'(count_q - SCW'(need) + SCW'(dup));
  assign count_d   = count_q - SCW'(need) + SCW'(dup) + SCW'(push);
  assign pval      = (exec && (type_q == OP_PRINT)) ? a : '0;

  // Write the stack and variable memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && exec && push) stack_mem[push_addr] <= r;
    if (cmd_i.commit && exec && (type_q == OP_STORE)) var_mem[slot] <= a;
  end

  // Update control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pc_q        <= '0;
      stopped_q   <= 1'b0;
      var_valid_q <= '0;
      plen_q      <= '0;
    end else begin
      if (cfg_we_i) plen_q <= cfg_wdata_i;
      if (cmd_i.commit) begin
        pc_q <= pc_d;
        if (stop) stopped_q <= 1'b1;
        if (exec) count_q <= count_d;
        if (exec && (type_q == OP_STORE)) var_valid_q[slot] <= 1'b1;
      end
    end
  end

  // Hold the result word until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)           out_valid_q <= 1'b0;
    else if (cmd_i.commit) out_valid_q <= 1'b1;
    else if (out_ready_i)  out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_pc_q  <= pc_d;
      out_pv_q  <= exec && (type_q == OP_PRINT);
      out_val_q <= pval;
      out_st_q  <= st;
    end
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o    = out_valid_q;
  assign next_pc_o      = out_pc_q;
  assign print_valid_o  = out_pv_q;
  assign print_value_o  = out_val_q;
  assign status_o       = out_st_q;

endmodule

`default_nettype wire

[hw/rtl/stack_bytecode_executor.sv]
// Top level of the stack bytecode executor
// Runs one bytecode word per accepted item and returns one result word with
// the next pc, an optional printed value and a status. A word passes through
// acceptance, memory read, evaluation and commit; divide or modulo also pass
// the one-bit-per-cycle divider. The result register lets the next word be
// accepted while a result waits. Halt, any error or leaving the program stops
// the block until reset. The user must write program_length only while the
// block is idle; the block itself does not enforce this.
`default_nettype none

module stack_bytecode_executor #(
  parameter int unsigned STACK_DEPTH = sbe_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VAR_COUNT   = sbe_pkg::VAR_COUNT_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire logic [sbe_pkg::PC_W-1:0] cfg_wdata_i,
  sbe_in_if.sink                        req_i,
  sbe_out_if.source                     rsp_o
);
  import sbe_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  sbe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (req_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sbe_datapath #(
    .STACK_DEPTH (STACK_DEPTH),
    .VAR_COUNT   (VAR_COUNT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (req_i.req_type),
    .int_operand_i (req_i.int_operand),
    .var_index_i   (req_i.var_index),
    .out_valid_o   (rsp_o.valid),
    .out_ready_i   (rsp_o.ready),
    .next_pc_o     (rsp_o.next_pc),
    .print_valid_o (rsp_o.print_valid),
    .print_value_o (rsp_o.print_value),
    .status_o      (rsp_o.status)
  );

endmodule

`default_nettype wire

[hw/rtl/sbe_checker.sv]
// Port-level assertions for the stack bytecode executor, bound to the top
`default_nettype none
`include "stack_bytecode_executor_defines.svh"

module sbe_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         out_valid_i,
  input wire logic                         out_ready_i,
  input wire logic                         print_valid_i,
  input wire logic [sbe_pkg::DATA_W-1:0]   print_value_i,
  input wire logic [sbe_pkg::STATUS_W-1:0] status_i
);
  import sbe_pkg::*;

  // A stalled result word stays offered
  `SBE_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped")

  // Status stays within the defined codes
  `SBE_ASSERT_NOW(a_status_range, out_valid_i, status_i <= ST_IGNORED, "bad status code")

  // Only an executed print reports a value
  `SBE_ASSERT_NOW(a_print_status, out_valid_i && print_valid_i, status_i == ST_OK || status_i == ST_LEFT, "print on fault")

  // No stray print value
  `SBE_ASSERT_NOW(a_print_zero, out_valid_i && !print_valid_i, print_value_i == '0, "stray print value")

endmodule

bind stack_bytecode_executor sbe_checker u_sbe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (rsp_o.valid),
  .out_ready_i   (rsp_o.ready),
  .print_valid_i (rsp_o.print_valid),
  .print_value_i (rsp_o.print_value),
  .status_i      (rsp_o.status)
);

`default_nettype wire
